@@ sv/tcw_pkg.sv @@
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared geometry, field widths, codes and types of the text console writer.
// ----------------------------------------------------------------------------
package tcw_pkg;

  localparam int COLUMNS    = 80;
  localparam int ROWS       = 25;
  localparam int CELL_COUNT = ROWS * COLUMNS;
  localparam int COPY_LEN   = CELL_COUNT - COLUMNS;
  localparam int SCROLL_POS = (ROWS - 1) * COLUMNS;

  localparam int ADDR_W = $clog2(CELL_COUNT);
  localparam int LIN_W  = $clog2(CELL_COUNT + 1);
  localparam int ROW_W  = $clog2(ROWS + 1);
  localparam int COL_W  = $clog2(COLUMNS + 1);

  localparam int REQ_W   = 2;
  localparam int CHAR_W  = 8;
  localparam int IDX_W   = 11;
  localparam int POS_W   = 11;
  localparam int CELL_W  = 16;
  localparam int COLOR_W = 8;

  localparam logic [REQ_W-1:0] REQ_PUT   = 2'd0;
  localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd1;
  localparam logic [REQ_W-1:0] REQ_READ  = 2'd2;

  localparam logic [CHAR_W-1:0] CH_BS    = 8'd8;
  localparam logic [CHAR_W-1:0] CH_NL    = 8'd10;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'd13;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

  localparam logic [CELL_W-1:0]  BLANK_CELL  = 16'h0F20;
  localparam logic [CELL_W-1:0]  SCROLL_FILL = 16'h0020;
  localparam logic [COLOR_W-1:0] COLOR_RESET = 8'h0F;

  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef enum logic [2:0] {
    OP_CHAR,
    OP_NL,
    OP_CR,
    OP_BS,
    OP_CLEAR,
    OP_READ,
    OP_NOP
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [CHAR_W-1:0] ch;
    logic [ADDR_W-1:0] idx;
    logic              idx_ok;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

@@ sv/tcw_if.sv @@
// ----------------------------------------------------------------------------
// tcw_if
// Request and response channel interfaces of the text console writer.
// ----------------------------------------------------------------------------
interface tcw_req_if;
  import tcw_pkg::*;

  logic              valid;
  logic              ready;
  logic [REQ_W-1:0]  req_type;
  logic [CHAR_W-1:0] char_code;
  logic [IDX_W-1:0]  cell_index;

  modport source (output valid, req_type, char_code, cell_index, input ready);
  modport sink   (input valid, req_type, char_code, cell_index, output ready);
endinterface

interface tcw_rsp_if;
  import tcw_pkg::*;

  logic              valid;
  logic              ready;
  logic [POS_W-1:0]  cursor_pos;
  logic [CELL_W-1:0] cell_value;
  logic              scrolled;

  modport source (output valid, cursor_pos, cell_value, scrolled, input ready);
  modport sink   (input valid, cursor_pos, cell_value, scrolled, output ready);
endinterface

@@ sv/tcw_front.sv @@
// ----------------------------------------------------------------------------
// tcw_front
// Accepts requests and decodes them into console commands for the queue.
// ----------------------------------------------------------------------------
module tcw_front (
  tcw_req_if.sink          in_req,
  input  tcw_pkg::q_stat_t qstat,
  input  logic             init_busy,
  output logic             push,
  output tcw_pkg::cmd_t    push_cmd
);
  import tcw_pkg::*;

  assign in_req.ready = !qstat.full && !init_busy;
  assign push         = in_req.valid && in_req.ready;

  always_comb begin
    push_cmd.ch     = in_req.char_code;
    push_cmd.idx    = ADDR_W'(in_req.cell_index);
    push_cmd.idx_ok = (32'(in_req.cell_index) < CELL_COUNT);
    case (in_req.req_type)
      REQ_PUT: begin
        case (in_req.char_code)
          CH_NL:   push_cmd.op = OP_NL;
          CH_CR:   push_cmd.op = OP_CR;
          CH_BS:   push_cmd.op = OP_BS;
          default: push_cmd.op = OP_CHAR;
        endcase
      end
      REQ_CLEAR: push_cmd.op = OP_CLEAR;
      REQ_READ:  push_cmd.op = OP_READ;
      default:   push_cmd.op = OP_NOP;
    endcase
  end

endmodule

@@ sv/tcw_queue.sv @@
// ----------------------------------------------------------------------------
// tcw_queue
// Short command queue between the decoder and the screen sequencer.
// ----------------------------------------------------------------------------
module tcw_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  tcw_pkg::cmd_t     push_cmd,
  input  logic              pop,
  output tcw_pkg::cmd_t     head,
  output tcw_pkg::q_stat_t  qstat
);
  import tcw_pkg::*;

  cmd_t              ent_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;

  function automatic logic [QPTR_W-1:0] step_ptr(input logic [QPTR_W-1:0] p);
    if (p == QPTR_W'(QDEPTH - 1)) begin
      step_ptr = '0;
    end else begin
      step_ptr = p + 1'b1;
    end
  endfunction

  assign head        = ent_r[rd_ptr_r];
  assign qstat.full  = (cnt_r == QCNT_W'(QDEPTH));
  assign qstat.empty = (cnt_r == '0);

  always_comb begin
    wr_ptr_nxt = push ? step_ptr(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = pop  ? step_ptr(rd_ptr_r) : rd_ptr_r;
    case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

@@ sv/tcw_back.sv @@
// ----------------------------------------------------------------------------
// tcw_back
// Screen sequencer: owns the cell memory, cursor and color, runs fills,
// scroll copies and reads, and holds the response register.
// ----------------------------------------------------------------------------
module tcw_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  tcw_pkg::cmd_t                head,
  input  tcw_pkg::q_stat_t             qstat,
  output logic                         pop,
  output logic                         init_busy,
  input  logic                         cfg_we,
  input  logic [tcw_pkg::COLOR_W-1:0]  cfg_wdata,
  tcw_rsp_if.source                    out_rsp
);
  import tcw_pkg::*;

  typedef enum logic [6:0] {
    S_INIT = 7'b0000001,
    S_IDLE = 7'b0000010,
    S_FILL = 7'b0000100,
    S_READ = 7'b0001000,
    S_COPY = 7'b0010000,
    S_BOT  = 7'b0100000,
    S_DONE = 7'b1000000
  } state_t;

  logic [CELL_W-1:0] mem [CELL_COUNT];

  state_t             state_r, state_nxt;
  logic [ROW_W-1:0]   row_r, row_nxt;
  logic [COL_W-1:0]   col_r, col_nxt;
  logic [LIN_W-1:0]   lin_r, lin_nxt;
  logic [LIN_W-1:0]   cnt_r, cnt_nxt;
  logic [COLOR_W-1:0] color_r;
  logic               cpend_r, cpend_nxt;
  logic [ADDR_W-1:0]  cdst_r, cdst_nxt;
  logic [CELL_W-1:0]  cell_r, cell_nxt;
  logic               scr_r, scr_nxt;
  logic               rdok_r, rdok_nxt;
  logic [CELL_W-1:0]  rdata_r;
  logic               ov_r;
  logic [POS_W-1:0]   opos_r;
  logic [CELL_W-1:0]  ocell_r;
  logic               oscr_r;

  logic               we;
  logic [ADDR_W-1:0]  waddr;
  logic [CELL_W-1:0]  wdata;
  logic [ADDR_W-1:0]  raddr;
  logic               load;
  logic               step_row;

  assign init_busy          = (state_r == S_INIT);
  assign out_rsp.valid      = ov_r;
  assign out_rsp.cursor_pos = opos_r;
  assign out_rsp.cell_value = ocell_r;
  assign out_rsp.scrolled   = oscr_r;

  always_comb begin
    state_nxt = state_r;
    row_nxt   = row_r;
    col_nxt   = col_r;
    lin_nxt   = lin_r;
    cnt_nxt   = cnt_r;
    cell_nxt  = cell_r;
    scr_nxt   = scr_r;
    rdok_nxt  = rdok_r;
    cpend_nxt = 1'b0;
    cdst_nxt  = cdst_r;
    pop       = 1'b0;
    we        = 1'b0;
    waddr     = '0;
    wdata     = '0;
    raddr     = '0;
    load      = 1'b0;
    step_row  = 1'b0;
    case (state_r)
      S_INIT, S_FILL: begin
        we      = 1'b1;
        waddr   = cnt_r[ADDR_W-1:0];
        wdata   = BLANK_CELL;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == LIN_W'(CELL_COUNT - 1)) begin
          state_nxt = (state_r == S_INIT) ? S_IDLE : S_DONE;
        end
      end
      S_IDLE: begin
        if (!qstat.empty) begin
          pop       = 1'b1;
          cell_nxt  = '0;
          scr_nxt   = 1'b0;
          state_nxt = S_DONE;
          case (head.op)
            OP_CHAR: begin
              we    = 1'b1;
              waddr = lin_r[ADDR_W-1:0];
              wdata = {color_r, head.ch};
              if (col_r == COL_W'(COLUMNS - 1)) begin
                step_row = 1'b1;
              end else begin
                col_nxt = col_r + 1'b1;
                lin_nxt = lin_r + 1'b1;
              end
            end
            OP_NL: step_row = 1'b1;
            OP_CR: begin
              col_nxt = '0;
              lin_nxt = lin_r - LIN_W'(col_r);
            end
            OP_BS: begin
              if (col_r != '0) begin
                col_nxt = col_r - 1'b1;
                lin_nxt = lin_r - 1'b1;
              end else if (row_r != '0) begin
                row_nxt = row_r - 1'b1;
                col_nxt = COL_W'(COLUMNS - 1);
                lin_nxt = lin_r - 1'b1;
              end
              we    = 1'b1;
              waddr = (lin_r == '0) ? '0 : ADDR_W'(lin_r - 1'b1);
              wdata = {color_r, CH_SPACE};
            end
            OP_CLEAR: begin
              row_nxt   = '0;
              col_nxt   = '0;
              lin_nxt   = '0;
              cnt_nxt   = '0;
              state_nxt = S_FILL;
            end
            OP_READ: begin
              raddr     = head.idx_ok ? head.idx : '0;
              rdok_nxt  = head.idx_ok;
              state_nxt = S_READ;
            end
            default: begin
            end
          endcase
          if (step_row) begin
            col_nxt = '0;
            if (row_r == ROW_W'(ROWS - 1)) begin
              lin_nxt   = LIN_W'(SCROLL_POS);
              scr_nxt   = 1'b1;
              cnt_nxt   = '0;
              state_nxt = S_COPY;
            end else begin
              row_nxt = row_r + 1'b1;
              lin_nxt = lin_r - LIN_W'(col_r) + LIN_W'(COLUMNS);
            end
          end
        end
      end
      S_READ: begin
        cell_nxt  = rdok_r ? rdata_r : '0;
        state_nxt = S_DONE;
      end
      S_COPY: begin
        raddr     = ADDR_W'(cnt_r + LIN_W'(COLUMNS));
        cpend_nxt = 1'b1;
        cdst_nxt  = cnt_r[ADDR_W-1:0];
        we        = cpend_r;
        waddr     = cdst_r;
        wdata     = rdata_r;
        cnt_nxt   = cnt_r + 1'b1;
        if (cnt_r == LIN_W'(COPY_LEN - 1)) begin
          state_nxt = S_BOT;
        end
      end
      S_BOT: begin
        we = 1'b1;
        if (cpend_r) begin
          waddr = cdst_r;
          wdata = rdata_r;
        end else begin
          waddr   = cnt_r[ADDR_W-1:0];
          wdata   = SCROLL_FILL;
          cnt_nxt = cnt_r + 1'b1;
          if (cnt_r == LIN_W'(CELL_COUNT - 1)) begin
            state_nxt = S_DONE;
          end
        end
      end
      S_DONE: begin
        if (!ov_r || out_rsp.ready) begin
          load      = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
      row_r   <= '0;
      col_r   <= '0;
      lin_r   <= '0;
      cnt_r   <= '0;
      color_r <= COLOR_RESET;
      cpend_r <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      row_r   <= row_nxt;
      col_r   <= col_nxt;
      lin_r   <= lin_nxt;
      cnt_r   <= cnt_nxt;
      cpend_r <= cpend_nxt;
      if (cfg_we) begin
        color_r <= cfg_wdata;
      end
      if (load) begin
        ov_r <= 1'b1;
      end else if (out_rsp.ready) begin
        ov_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cdst_r <= cdst_nxt;
    cell_r <= cell_nxt;
    scr_r  <= scr_nxt;
    rdok_r <= rdok_nxt;
    if (load) begin
      opos_r  <= POS_W'(lin_r);
      ocell_r <= cell_r;
      oscr_r  <= scr_r;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

endmodule

@@ sv/text_console_writer.sv @@
// ----------------------------------------------------------------------------
// text_console_writer
// Character-cell text console with cursor, scroll and clear.
// ----------------------------------------------------------------------------
// Sequencing: put, return, newline and backspace update the cell memory and
// cursor directly; a read goes through the screen RAM read register; a clear
// fills every cell; a put that scrolls copies rows through the screen RAM, one
// read and one write per cycle, then fills the bottom row.
// Flow: the command queue takes new requests while the screen sequencer is
// still busy with earlier ones, until the queue is full. Reset: a clearing
// pass writes every cell, in_req.ready stays low meanwhile; config writes are taken throughout.
// ----------------------------------------------------------------------------
module text_console_writer (
  input  logic                         clk,
  input  logic                         rst_n,
  tcw_req_if.sink                      in_req,
  tcw_rsp_if.source                    out_rsp,
  input  logic                         cfg_we,
  input  logic [tcw_pkg::COLOR_W-1:0]  cfg_wdata
);
  import tcw_pkg::*;

  cmd_t    push_cmd;
  cmd_t    head;
  q_stat_t qstat;
  logic    push;
  logic    pop;
  logic    init_busy;

  tcw_front u_front (
    .in_req    (in_req),
    .qstat     (qstat),
    .init_busy (init_busy),
    .push      (push),
    .push_cmd  (push_cmd)
  );

  tcw_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .qstat    (qstat)
  );

  tcw_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .qstat     (qstat),
    .pop       (pop),
    .init_busy (init_busy),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .out_rsp   (out_rsp)
  );

endmodule

@@ sv/tcw_check.sv @@
// ----------------------------------------------------------------------------
// tcw_check
// Port-level checks of the text console writer, bound to the top level.
// ----------------------------------------------------------------------------
module tcw_check (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [tcw_pkg::POS_W-1:0]   out_cursor_pos,
  input logic [tcw_pkg::CELL_W-1:0]  out_cell_value,
  input logic                        out_scrolled
);
  import tcw_pkg::*;

  logic [3:0] pend_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      case ({in_valid && in_ready, out_valid && out_ready})
        2'b10:   pend_r <= pend_r + 1'b1;
        2'b01:   pend_r <= pend_r - 1'b1;
        default: pend_r <= pend_r;
      endcase
    end
  end

  a_no_spurious_rsp: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (pend_r != '0))
    else $error("response without a pending item");

  a_init_blocks_input: assert property (@(posedge clk)
    $rose(rst_n) |-> !in_ready)
    else $error("input accepted during clearing pass");

  a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_cursor_pos)
      && $stable(out_cell_value) && $stable(out_scrolled))
    else $error("stalled response changed");

  a_scroll_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_scrolled |-> (out_cursor_pos == POS_W'(SCROLL_POS)))
    else $error("scroll left cursor off bottom row start");

endmodule

bind text_console_writer tcw_check u_tcw_check (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_req.valid),
  .in_ready       (in_req.ready),
  .out_valid      (out_rsp.valid),
  .out_ready      (out_rsp.ready),
  .out_cursor_pos (out_rsp.cursor_pos),
  .out_cell_value (out_rsp.cell_value),
  .out_scrolled   (out_rsp.scrolled)
);

@@ verif/tb_text_console_writer.sv @@
// ----------------------------------------------------------------------------
// tb_text_console_writer
// Self-checking bench for the text console writer. A scripted run covers
// the edge cases, then random request streams at several text colors. A
// cell-accurate screen and cursor predictor is compared field by field with
// every response, except for scripted rows that give fixed expected values.
// ----------------------------------------------------------------------------
module tb_text_console_writer;
  timeunit 1ns;
  timeprecision 1ps;

  import tcw_pkg::*;

  localparam logic [REQ_W-1:0] REQ_NONE = 2'd3;
  localparam int STALL_LIMIT = 20000;
  localparam int ITEMS_PER_PHASE = 150;
  localparam int PHASES = 5;
  localparam int SCRIPT_LEN = 23;

  typedef struct packed {
    logic [POS_W-1:0]  pos;
    logic [CELL_W-1:0] cval;
    logic              scr;
  } console_rsp_t;

  typedef struct packed {
    logic [REQ_W-1:0]  req;
    logic [CHAR_W-1:0] ch;
    logic [IDX_W-1:0]  idx;
  } console_req_t;

  typedef struct packed {
    logic [REQ_W-1:0]  req;
    logic [CHAR_W-1:0] ch;
    logic [IDX_W-1:0]  idx;
    logic [7:0]        reps;
    logic              fixed;
    logic [POS_W-1:0]  pos;
    logic [CELL_W-1:0] cval;
    logic              scr;
  } step_row_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [COLOR_W-1:0] cfg_wdata;

  tcw_req_if in_req ();
  tcw_rsp_if out_rsp ();

  text_console_writer u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_req    (in_req),
    .out_rsp   (out_rsp),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  logic [CELL_W-1:0]  screen_img [CELL_COUNT];
  int unsigned        cur_row;
  int unsigned        cur_col;
  logic [COLOR_W-1:0] text_attr;

  console_rsp_t pending_rsp [$];
  console_rsp_t row_exp;
  logic         row_fixed;
  logic         calm;
  int           fail_count;
  int           stall_cycles;

  step_row_t script [SCRIPT_LEN] = '{
    '{REQ_READ,  8'h00, 11'd0,    8'd1,  1'b1, 11'd0,    16'h0F20, 1'b0},
    '{REQ_READ,  8'hFF, 11'd1999, 8'd1,  1'b1, 11'd0,    16'h0F20, 1'b0},
    '{REQ_READ,  8'h00, 11'd2047, 8'd1,  1'b1, 11'd0,    16'h0000, 1'b0},
    '{REQ_NONE,  8'hFF, 11'd2047, 8'd1,  1'b1, 11'd0,    16'h0000, 1'b0},
    '{REQ_PUT,   CH_BS, 11'd0,    8'd1,  1'b1, 11'd0,    16'h0000, 1'b0},
    '{REQ_PUT,   8'h41, 11'd0,    8'd1,  1'b1, 11'd1,    16'h0000, 1'b0},
    '{REQ_READ,  8'h00, 11'd0,    8'd1,  1'b1, 11'd1,    16'h0F41, 1'b0},
    '{REQ_PUT,   CH_BS, 11'd0,    8'd1,  1'b1, 11'd0,    16'h0000, 1'b0},
    '{REQ_READ,  8'h00, 11'd0,    8'd1,  1'b1, 11'd0,    16'h0F20, 1'b0},
    '{REQ_PUT,   8'hFF, 11'd0,    8'd1,  1'b1, 11'd1,    16'h0000, 1'b0},
    '{REQ_PUT,   8'h00, 11'd0,    8'd1,  1'b1, 11'd2,    16'h0000, 1'b0},
    '{REQ_PUT,   CH_CR, 11'd0,    8'd1,  1'b1, 11'd0,    16'h0000, 1'b0},
    '{REQ_PUT,   CH_NL, 11'd0,    8'd1,  1'b1, 11'd80,   16'h0000, 1'b0},
    '{REQ_PUT,   CH_BS, 11'd0,    8'd1,  1'b1, 11'd79,   16'h0000, 1'b0},
    '{REQ_READ,  8'h00, 11'd79,   8'd1,  1'b1, 11'd79,   16'h0F20, 1'b0},
    '{REQ_PUT,   8'h78, 11'd0,    8'd81, 1'b0, 11'd0,    16'h0000, 1'b0},
    '{REQ_PUT,   CH_NL, 11'd0,    8'd22, 1'b0, 11'd0,    16'h0000, 1'b0},
    '{REQ_PUT,   8'h79, 11'd0,    8'd80, 1'b0, 11'd0,    16'h0000, 1'b0},
    '{REQ_READ,  8'h00, 11'd1920, 8'd1,  1'b1, 11'd1920, 16'h0020, 1'b0},
    '{REQ_PUT,   CH_NL, 11'd0,    8'd1,  1'b1, 11'd1920, 16'h0000, 1'b1},
    '{REQ_READ,  8'h00, 11'd1839, 8'd1,  1'b0, 11'd0,    16'h0000, 1'b0},
    '{REQ_CLEAR, 8'h00, 11'd0,    8'd1,  1'b1, 11'd0,    16'h0000, 1'b0},
    '{REQ_READ,  8'h00, 11'd1999, 8'd1,  1'b1, 11'd0,    16'h0F20, 1'b0}
  };

  function automatic console_rsp_t console_apply(console_req_t rq);
    console_rsp_t r;
    int unsigned  lin;
    r = '0;
    case (rq.req)
      REQ_PUT: begin
        case (rq.ch)
          CH_NL: begin
            cur_col = 0;
            cur_row++;
          end
          CH_CR: cur_col = 0;
          CH_BS: begin
            if (cur_col > 0) begin
              cur_col--;
            end else if (cur_row > 0) begin
              cur_row--;
              cur_col = COLUMNS - 1;
            end
            lin = cur_row * COLUMNS + cur_col;
            screen_img[lin] = {text_attr, CH_SPACE};
          end
          default: begin
            lin = cur_row * COLUMNS + cur_col;
            screen_img[lin] = {text_attr, rq.ch};
            cur_col++;
            if (cur_col >= COLUMNS) begin
              cur_col = 0;
              cur_row++;
            end
          end
        endcase
        if (cur_row >= ROWS) begin
          for (int i = 0; i < COPY_LEN; i++) screen_img[i] = screen_img[i + COLUMNS];
          for (int i = COPY_LEN; i < CELL_COUNT; i++) screen_img[i] = SCROLL_FILL;
          cur_row = ROWS - 1;
          r.scr = 1'b1;
        end
      end
      REQ_CLEAR: begin
        for (int i = 0; i < CELL_COUNT; i++) screen_img[i] = BLANK_CELL;
        cur_row = 0;
        cur_col = 0;
      end
      REQ_READ: begin
        if (rq.idx < CELL_COUNT) r.cval = screen_img[rq.idx];
      end
      default: ;
    endcase
    r.pos = POS_W'(cur_row * COLUMNS + cur_col);
    return r;
  endfunction

  function automatic console_req_t random_req();
    console_req_t rq;
    int unsigned  pick;
    rq.req = REQ_PUT;
    rq.ch  = CHAR_W'($urandom_range(255));
    rq.idx = IDX_W'($urandom_range(2047));
    pick = $urandom_range(99);
    if (pick < 55) begin
      rq.req = REQ_PUT;
    end else if (pick < 65) begin
      rq.ch = CH_NL;
    end else if (pick < 69) begin
      rq.ch = CH_CR;
    end else if (pick < 77) begin
      rq.ch = CH_BS;
    end else if (pick < 96) begin
      rq.req = REQ_READ;
      if (pick < 92) rq.idx = IDX_W'($urandom_range(CELL_COUNT - 1));
    end else if (pick < 98) begin
      rq.req = REQ_NONE;
    end else if (pick < 99) begin
      rq.req = REQ_CLEAR;
    end else begin
      rq.ch = CH_NL;
    end
    return rq;
  endfunction

  task automatic send_req(console_req_t rq, logic fixed, console_rsp_t exp);
    if (!calm && $urandom_range(99) < 9) begin
      in_req.valid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk);
    end
    in_req.valid      <= 1'b1;
    in_req.req_type   <= rq.req;
    in_req.char_code  <= rq.ch;
    in_req.cell_index <= rq.idx;
    row_fixed         <= fixed;
    row_exp           <= exp;
    do @(posedge clk); while (!in_req.ready);
  endtask

  task automatic drain();
    in_req.valid <= 1'b0;
    @(posedge clk);
    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_color(logic [COLOR_W-1:0] c);
    cfg_we    <= 1'b1;
    cfg_wdata <= c;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial clk = 1'b0;
  always #1 clk = ~clk;

  always @(posedge clk) begin
    out_rsp.ready <= calm || ($urandom_range(99) >= 9);
  end

  always @(posedge clk) begin : scoreboard
    console_rsp_t got;
    console_rsp_t want;
    console_rsp_t pred;
    if (out_rsp.valid && out_rsp.ready) begin
      got = '{out_rsp.cursor_pos, out_rsp.cell_value, out_rsp.scrolled};
      if (pending_rsp.size() == 0) begin
        $error("unexpected response: cursor_pos %0d cell_value %h scrolled %0d",
               got.pos, got.cval, got.scr);
        fail_count++;
      end else begin
        want = pending_rsp.pop_front();
        if (got.pos !== want.pos) begin
          $error("cursor_pos: expected %0d, got %0d", want.pos, got.pos);
          fail_count++;
        end
        if (got.cval !== want.cval) begin
          $error("cell_value: expected %h, got %h", want.cval, got.cval);
          fail_count++;
        end
        if (got.scr !== want.scr) begin
          $error("scrolled: expected %0d, got %0d", want.scr, got.scr);
          fail_count++;
        end
      end
    end
    if (cfg_we) text_attr = cfg_wdata;
    if (rst_n && in_req.valid && in_req.ready) begin
      pred = console_apply('{in_req.req_type, in_req.char_code, in_req.cell_index});
      pending_rsp.push_back(row_fixed ? row_exp : pred);
    end
  end

  always @(posedge clk) begin
    if ((in_req.valid && in_req.ready) || (out_rsp.valid && out_rsp.ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    console_req_t rq;
    step_row_t    row;
    logic [COLOR_W-1:0] colors [PHASES];
    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_wdata         = '0;
    in_req.valid      = 1'b0;
    in_req.req_type   = REQ_PUT;
    in_req.char_code  = '0;
    in_req.cell_index = '0;
    out_rsp.ready     = 1'b0;
    row_fixed         = 1'b0;
    row_exp           = '0;
    calm              = 1'b0;
    fail_count        = 0;
    stall_cycles      = 0;
    for (int i = 0; i < CELL_COUNT; i++) screen_img[i] = BLANK_CELL;
    cur_row   = 0;
    cur_col   = 0;
    text_attr = COLOR_RESET;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    for (int r = 0; r < SCRIPT_LEN; r++) begin
      row = script[r];
      for (int k = 0; k < row.reps; k++) begin
        send_req('{row.req, row.ch, row.idx}, row.fixed, '{row.pos, row.cval, row.scr});
      end
    end
    drain();

    colors[0] = 8'h00;
    colors[1] = 8'hFF;
    colors[2] = COLOR_W'($urandom_range(255));
    colors[3] = COLOR_W'($urandom_range(255));
    colors[4] = COLOR_RESET;
    for (int p = 0; p < PHASES; p++) begin
      write_color(colors[p]);
      calm <= (p == 2);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        rq = random_req();
        send_req(rq, 1'b0, '0);
        if ($urandom_range(59) == 0) drain();
      end
      drain();
    end

    calm <= 1'b0;
    repeat (2 * CELL_COUNT) @(posedge clk);
    if (fail_count == 0 && pending_rsp.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
